>>> sv/slir_pkg.sv
package slir_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int CNT_OUT_W    = 5;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

>>> sv/slir_ctrl.sv
module slir_ctrl
    import slir_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        busy       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = start;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                busy       = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/slir_dpath.sv
module slir_dpath
    import slir_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic                        i_opcode,
    input  logic signed [DATA_W-1:0]    i_value,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic        [CNT_OUT_W-1:0] o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] r_entries [CAPACITY];
    logic signed [DATA_W-1:0] n_entries [CAPACITY];
    logic        [CW-1:0]     r_count;
    logic        [CW-1:0]     n_count;
    logic                     r_op;
    logic signed [DATA_W-1:0] r_val;
    logic                     r_valid;
    logic                     r_ok;
    logic                     n_ok;
    logic        [CAPACITY-1:0] w_lt;
    logic        [CAPACITY-1:0] w_eq;
    logic                     w_full;
    logic                     w_found;
    logic        [CW+CNT_OUT_W-1:0] w_cnt_ext;

    // per-cell compare against the item value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt[i] = (CW'(i) < r_count) && (r_entries[i] < r_val);
            w_eq[i] = (CW'(i) < r_count) && (r_entries[i] == r_val);
        end
    end

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_found = |w_eq;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entries[i] = r_entries[i];
        end
        n_count = r_count;
        n_ok    = 1'b0;
        if (r_op == OP_INSERT) begin
            if (!w_full) begin
                n_ok    = 1'b1;
                n_count = r_count + CW'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!w_lt[i]) begin
                        if (i == 0) begin
                            n_entries[i] = r_val;
                        end else if (w_lt[i-1]) begin
                            n_entries[i] = r_val;
                        end else begin
                            n_entries[i] = r_entries[i-1];
                        end
                    end
                end
            end
        end else begin
            if (w_found) begin
                n_ok    = 1'b1;
                n_count = r_count - CW'(1);
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (!w_lt[i]) begin
                        n_entries[i] = r_entries[i+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_val <= i_value;
        end
        if (i_cmd.exec) begin
            r_ok <= n_ok;
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
        end
    end

    assign w_cnt_ext     = {{CNT_OUT_W{1'b0}}, r_count};
    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_entry_count = w_cnt_ext[CNT_OUT_W-1:0];

endmodule

>>> sv/sorted_list_insert_remove.sv
// an item is latched on acceptance, then ST_EXEC writes the list and registers o_valid
// items are taken only while busy is low; busy is high for the single compare-and-shift cycle
// all register cells compare and shift in parallel in that cycle
// reset: synchronous active low, empties the list (count 0), no clearing pass
// the result strobe lasts one cycle and cannot be stalled by the receiver
module sorted_list_insert_remove
    import slir_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_opcode,
    input  logic signed [DATA_W-1:0]    i_value,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic        [CNT_OUT_W-1:0] o_entry_count
);

    t_cmd w_cmd;

    slir_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    slir_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_entry_count (o_entry_count)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("work cycle did not give one result");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("not idle after reset");
`endif

endmodule
